FILE: rtl/slot_table_oldest_eviction_assert.svh
// assertion macros for the slot table
`ifndef SLOT_TABLE_OLDEST_EVICTION_ASSERT_SVH
`define SLOT_TABLE_OLDEST_EVICTION_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define STOE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("slot table check failed");
// condition in one cycle implies a condition in the next cycle
`define STOE_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("slot table sequence check failed");
`else
`define STOE_ASSERT(lbl, clk, rst, prop)
`define STOE_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

FILE: rtl/stoe_pkg.sv
// shared types and constants for the slot table
`default_nettype none
package stoe_pkg;

  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 6;
  localparam int STAMP_W = 31;

  localparam logic [STAMP_W-1:0] STAMP_MAX = 31'h7FFF_FFFF;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FIND_FREE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OCCUPY     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PREV       = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RANK       = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SELECT     = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic find_step;
    logic evict;
    logic reduce;
    logic circ_step;
    logic move;
    logic rank_step;
    logic publish;
  } stoe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic free_hit;
    logic scan_last;
    logic move_req;
    logic red_ok;
    logic circ_hit;
    logic circ_last;
    logic out_free;
  } stoe_sts_t;

endpackage
`default_nettype wire

FILE: rtl/stoe_ctrl.sv
// command sequencer for the slot table
`default_nettype none
module stoe_ctrl
  import stoe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] command,
  output logic                  in_stall,
  output stoe_cmd_t             ctl,
  input  wire stoe_sts_t        sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_FIND   = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_EVICT  = 4'd4;
  localparam logic [3:0] S_REDUCE = 4'd5;
  localparam logic [3:0] S_CIRC   = 4'd6;
  localparam logic [3:0] S_MOVE   = 4'd7;
  localparam logic [3:0] S_RANK   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          if (command == CMD_FIND_FREE) begin
            state_next = S_FIND;
          end else if (command inside {CMD_NEXT, CMD_PREV}) begin
            state_next = S_REDUCE;
          end else if (command == CMD_RANK) begin
            state_next = S_RANK;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = sts.move_req ? S_MOVE : S_DONE;
      end
      S_FIND: begin
        ctl.find_step = 1'b1;
        if (sts.free_hit) begin
          state_next = S_DONE;
        end else if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EVICT;
      end
      S_EVICT: begin
        ctl.evict  = 1'b1;
        state_next = sts.move_req ? S_MOVE : S_DONE;
      end
      S_REDUCE: begin
        ctl.reduce = 1'b1;
        if (sts.red_ok) begin
          state_next = S_CIRC;
        end
      end
      S_CIRC: begin
        ctl.circ_step = 1'b1;
        if (sts.circ_hit || sts.circ_last) begin
          state_next = S_DONE;
        end
      end
      S_MOVE: begin
        ctl.circ_step = 1'b1;
        ctl.move      = 1'b1;
        if (sts.circ_hit || sts.circ_last) begin
          state_next = S_DONE;
        end
      end
      S_RANK: begin
        ctl.rank_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/stoe_datapath.sv
// slot state, stamp memory, scan logic and result register
`default_nettype none
`include "slot_table_oldest_eviction_assert.svh"
module stoe_datapath
  import stoe_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire stoe_cmd_t         ctl,
  output stoe_sts_t              sts,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   status,
  output logic [SLOT_W-1:0]      result_slot,
  output logic [CNT_W-1:0]       rank,
  output logic [CNT_W-1:0]       occupied_count,
  output logic [SLOT_W-1:0]      current_slot,
  output logic                   current_valid
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int WW = IW + SLOT_W;

  // low bits of an index as a result slot field
  function automatic logic [SLOT_W-1:0] lo5(input logic [IW-1:0] v);
    logic [WW-1:0] w;
    w = {{SLOT_W{1'b0}}, v};
    return w[SLOT_W-1:0];
  endfunction

  // saturate a count to the output field
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CW-1:0] v);
    logic [CW+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, v};
    return (w > {{CW{1'b0}}, {CNT_W{1'b1}}}) ? {CNT_W{1'b1}} : w[CNT_W-1:0];
  endfunction

  // table state
  logic [SLOTS-1:0]   occ;
  logic [STAMP_W-1:0] stamp_cnt;
  logic [IW-1:0]      cur;
  logic               cur_present;
  logic [CW-1:0]      occ_cnt;
  logic [STAMP_W-1:0] stamp_mem [SLOTS];
  logic [STAMP_W-1:0] rd_data;

  // per-item working registers
  logic [CMD_W-1:0]   cmd_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  red;
  logic [IW-1:0]      ptr;
  logic [IW-1:0]      steps;
  logic [STAMP_W-1:0] best;
  logic [IW-1:0]      bidx;
  logic               cmp_vld;
  logic [IW-1:0]      cmp_idx;
  logic               res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [CW-1:0]      res_rank;

  // operand decode
  logic [WW-1:0] slot_w;
  logic [WW-1:0] ptr_w;
  logic [WW-1:0] red_w;
  logic [WW-1:0] red_sub;
  logic [IW-1:0] slot_idx;
  logic          in_range;
  logic          rm_ok;
  logic          ocp_ok;
  logic          wr_en;
  logic          free_en;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] nidx_up;
  logic [IW-1:0] nidx_dn;
  logic [IW-1:0] nidx;
  logic          go_up;
  logic          circ_hit;

  assign slot_w   = {{IW{1'b0}}, slot_r};
  assign ptr_w    = {{SLOT_W{1'b0}}, ptr};
  assign red_w    = {{IW{1'b0}}, red};
  assign red_sub  = red_w - WW'(SLOTS);
  assign slot_idx = slot_w[IW-1:0];
  assign in_range = slot_w < WW'(SLOTS);
  assign rm_ok    = in_range && occ[slot_idx];
  assign ocp_ok   = in_range && !occ[slot_idx];
  assign wr_en    = ctl.exec && (cmd_r == CMD_OCCUPY) && ocp_ok;

  // freeing a slot by remove or by eviction
  assign free_en  = (ctl.exec && (cmd_r == CMD_REMOVE) && rm_ok) ||
                    (ctl.evict && (best != STAMP_MAX));
  assign free_idx = ctl.evict ? bidx : slot_idx;

  // circular step
  assign nidx_up  = (ptr == IW'(SLOTS - 1)) ? '0 : ptr + 1'b1;
  assign nidx_dn  = (ptr == '0) ? IW'(SLOTS - 1) : ptr - 1'b1;
  assign go_up    = ctl.move || (cmd_r == CMD_NEXT);
  assign nidx     = go_up ? nidx_up : nidx_dn;
  assign circ_hit = occ[nidx];

  // status to controller
  always_comb begin
    sts           = '0;
    sts.free_hit  = !occ[ptr];
    sts.scan_last = (ptr == IW'(SLOTS - 1));
    sts.move_req  = free_en && cur_present && (cur == free_idx);
    sts.red_ok    = red_w < WW'(SLOTS);
    sts.circ_hit  = circ_hit;
    sts.circ_last = (steps == IW'(SLOTS - 1));
    sts.out_free  = !out_valid || !out_stall;
  end

  // stamp memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[slot_idx] <= stamp_cnt;
    end
    rd_data <= stamp_mem[ptr];
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      stamp_cnt   <= '0;
      cur         <= '0;
      cur_present <= 1'b0;
      occ_cnt     <= '0;
      out_valid   <= 1'b0;
      cmp_vld     <= 1'b0;
    end else begin
      cmp_vld <= ctl.find_step && occ[ptr];
      if (ctl.exec) begin
        case (cmd_r)
          CMD_OCCUPY: begin
            if (ocp_ok) begin
              occ[slot_idx] <= 1'b1;
              occ_cnt       <= occ_cnt + 1'b1;
              if (stamp_cnt != STAMP_MAX) begin
                stamp_cnt <= stamp_cnt + 1'b1;
              end
            end
          end
          CMD_REMOVE_ALL: begin
            occ         <= '0;
            stamp_cnt   <= '0;
            cur         <= '0;
            cur_present <= 1'b0;
            occ_cnt     <= '0;
          end
          CMD_SELECT: begin
            if (rm_ok) begin
              cur         <= slot_idx;
              cur_present <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (free_en) begin
        occ[free_idx] <= 1'b0;
        occ_cnt       <= occ_cnt - 1'b1;
      end
      // current pointer follows to the next occupied slot
      if (ctl.circ_step && ctl.move) begin
        if (circ_hit) begin
          cur <= nidx;
        end else if (sts.circ_last) begin
          cur         <= '0;
          cur_present <= 1'b0;
        end
      end
      if (ctl.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    cmp_idx <= ptr;
    if (ctl.load) begin
      cmd_r      <= command;
      slot_r     <= slot;
      red        <= slot;
      ptr        <= '0;
      steps      <= '0;
      best       <= STAMP_MAX;
      bidx       <= '0;
      res_status <= 1'b0;
      res_slot   <= (command == CMD_RANK) ? slot : '0;
      res_rank   <= '0;
    end
    // occupy, remove and select in the exec step
    if (ctl.exec && (cmd_r != CMD_REMOVE_ALL)) begin
      if ((cmd_r == CMD_OCCUPY) ? ocp_ok : rm_ok) begin
        res_slot <= slot_r;
      end else begin
        res_status <= 1'b1;
      end
      ptr   <= slot_idx;
      steps <= '0;
    end
    // free slot scan, stamps compared in the cycle after their slot is scanned
    if (ctl.find_step) begin
      if (!occ[ptr]) begin
        res_slot <= lo5(ptr);
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
    if (cmp_vld && (rd_data < best)) begin
      best <= rd_data;
      bidx <= cmp_idx;
    end
    if (ctl.evict) begin
      if (best != STAMP_MAX) begin
        res_slot <= lo5(bidx);
        ptr      <= bidx;
        steps    <= '0;
      end else begin
        res_status <= 1'b1;
      end
    end
    // bring the search start into the table range
    if (ctl.reduce) begin
      if (!sts.red_ok) begin
        red <= red_sub[SLOT_W-1:0];
      end else begin
        ptr   <= red_w[IW-1:0];
        steps <= '0;
      end
    end
    if (ctl.circ_step) begin
      ptr   <= nidx;
      steps <= steps + 1'b1;
      if (!ctl.move) begin
        if (circ_hit) begin
          res_slot <= lo5(nidx);
        end else if (sts.circ_last) begin
          res_status <= 1'b1;
        end
      end
    end
    if (ctl.rank_step) begin
      if (occ[ptr] && (ptr_w <= slot_w)) begin
        res_rank <= res_rank + 1'b1;
      end
      ptr <= ptr + 1'b1;
    end
    if (ctl.publish) begin
      status         <= res_status;
      result_slot    <= res_slot;
      rank           <= sat_cnt(res_rank);
      occupied_count <= sat_cnt(occ_cnt);
      current_slot   <= lo5(cur);
      current_valid  <= cur_present && occ[cur];
    end
  end

  `STOE_ASSERT(a_count_tracks_bits, clk, rst, occ_cnt == CW'($countones(occ)))
  `STOE_ASSERT(a_idle_pointer_zero, clk, rst, cur_present || (cur == '0))
  `STOE_ASSERT_NEXT(a_move_lands_occupied, clk, rst, ctl.circ_step && ctl.move && circ_hit, cur_present && occ[cur])

endmodule
`default_nettype wire

FILE: rtl/slot_table_oldest_eviction.sv
// top level of the slot table with oldest-first eviction
`default_nettype none
// Slot table with an occupied bit and an age stamp per slot. One command is
// taken at a time and gives one result. Remove, and find-free when it must
// evict, also move the current pointer on to the next occupied slot when the
// freed slot is the current one. Next and prev first subtract SLOTS from the
// start slot until it lies in the table range; rank scans every slot. The
// scan looks at one slot per cycle through the occupied bits and the single
// read port of the stamp memory. A new command is accepted while the previous
// result still waits.
module slot_table_oldest_eviction
  import stoe_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [SLOT_W-1:0] slot,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   status,
  output logic [SLOT_W-1:0]      result_slot,
  output logic [CNT_W-1:0]       rank,
  output logic [CNT_W-1:0]       occupied_count,
  output logic [SLOT_W-1:0]      current_slot,
  output logic                   current_valid
);

  stoe_cmd_t ctl;
  stoe_sts_t sts;

  // sequencer
  stoe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  // table and result register
  stoe_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .command        (command),
    .slot           (slot),
    .ctl            (ctl),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .result_slot    (result_slot),
    .rank           (rank),
    .occupied_count (occupied_count),
    .current_slot   (current_slot),
    .current_valid  (current_valid)
  );

endmodule
`default_nettype wire
